>>> rtl/lpht_pkg.sv
`default_nettype none
package lpht_pkg;

  // Default sizing of the table
  localparam int DEF_CAPACITY    = 256;
  localparam int DEF_KEY_WIDTH   = 32;
  localparam int DEF_VALUE_WIDTH = 32;

  // Field widths of the request and result
  localparam int OP_W     = 2;
  localparam int KEY_W    = 32;
  localparam int HASH_W   = 32;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 8;
  localparam int OCC_W    = 9;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STS_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] STS_REPLACED  = 3'd1;
  localparam logic [STATUS_W-1:0] STS_REMOVED   = 3'd2;
  localparam logic [STATUS_W-1:0] STS_FOUND     = 3'd3;
  localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] STS_FULL      = 3'd5;

  // Slot state codes held in the table memory
  localparam int SLOT_ST_W = 2;
  localparam logic [SLOT_ST_W-1:0] SLOT_EMPTY = 2'd0;
  localparam logic [SLOT_ST_W-1:0] SLOT_USED  = 2'd1;
  localparam logic [SLOT_ST_W-1:0] SLOT_TOMB  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [KEY_W-1:0]   key;
    logic [HASH_W-1:0]  hash;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value_out;
    logic [SLOT_W-1:0]   slot;
    logic [OCC_W-1:0]    occupied;
  } rsp_t;

endpackage
`default_nettype wire

>>> rtl/lpht_ram.sv
`default_nettype none
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/linear_probe_hash_table_unit.sv
`default_nettype none
// Open-addressing key/value table with linear probing and tombstones. Each
// request asks to insert (or replace), remove or look up a key, and gives
// exactly one result. State, key and value of every slot share one memory
// with a registered read. After reset the block clears that memory, one
// slot a cycle, and takes no request until every slot is clear. A request
// then probes one slot a cycle from its start slot, reads issued back to
// back; when CAPACITY is not a power of two the start slot is first reduced
// from the hash by a reciprocal multiplication and a subtract. A finished
// result sits in an output register, so the next request is accepted while
// it waits to be taken.
module linear_probe_hash_table_unit #(
  parameter int CAPACITY    = lpht_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH   = lpht_pkg::DEF_KEY_WIDTH,
  parameter int VALUE_WIDTH = lpht_pkg::DEF_VALUE_WIDTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire lpht_pkg::req_t in_req,
  output logic                out_valid,
  input  wire logic           out_stall,
  output lpht_pkg::rsp_t      out_rsp
);

  import lpht_pkg::*;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int WORD_W = SLOT_ST_W + KEY_WIDTH + VALUE_WIDTH;
  localparam bit IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
  localparam int PROD_W = 2 * HASH_W + 1;

  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(CAPACITY - 1);

  // Rounded-up reciprocal of CAPACITY: the quotient of any 32-bit hash is
  // exact after the multiply and a right shift by HASH_W + IDX_W
  localparam int RED_SH = HASH_W + IDX_W;
  localparam logic [63:0] RECIP_W =
    ((64'd1 << RED_SH) + 64'(CAPACITY) - 64'd1) / 64'(CAPACITY);
  localparam logic [HASH_W:0] RECIP_M = RECIP_W[HASH_W:0];

  // Controller states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;
  localparam logic [2:0] S_REM   = 3'd5;

  // Control state
  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;
  logic             rvld_r, rvld_nxt;
  logic [CNT_W-1:0] ex_r, ex_nxt;
  logic             have_tomb_r, have_tomb_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_vld_r, out_vld_nxt;

  // Payload
  logic [OP_W-1:0]        op_r, op_nxt;
  logic [KEY_WIDTH-1:0]   key_r, key_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [HASH_W-1:0]      hsh_r, hsh_nxt;
  logic [PROD_W-1:0]      prod_r, prod_nxt;
  logic [IDX_W-1:0]       p_r, p_nxt;
  logic [IDX_W-1:0]       q_r, q_nxt;
  logic [IDX_W-1:0]       tomb_r, tomb_nxt;
  rsp_t                   res_r, res_nxt;
  rsp_t                   out_r, out_nxt;

  // Memory port
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] rdata;

  logic [SLOT_ST_W-1:0]   rd_st;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic                   hit;
  logic                   last;
  logic                   is_ins;
  logic                   is_rem;
  logic [HASH_W-1:0]      quo;
  logic [HASH_W-1:0]      rem;
  logic [IDX_W-1:0]       p_inc;
  logic [IDX_W-1:0]       tgt;

  lpht_ram #(
    .WIDTH(WORD_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(p_r),
    .rdata(rdata)
  );

  assign rd_st  = rdata[WORD_W-1 -: SLOT_ST_W];
  assign rd_key = rdata[VALUE_WIDTH +: KEY_WIDTH];
  assign rd_val = rdata[0 +: VALUE_WIDTH];

  // Memory data arrives in the cycle after its address, so q_r tags it
  assign hit    = (rd_st == SLOT_USED) && (rd_key == key_r);
  assign last   = (ex_r == CNT_LAST);
  assign is_ins = (op_r == OP_INSERT);
  assign is_rem = (op_r == OP_REMOVE);
  assign p_inc  = (p_r == IDX_LAST) ? '0 : p_r + 1'b1;
  // First tombstone wins over the slot that ends the probe
  assign tgt    = have_tomb_r ? tomb_r : q_r;

  // Start slot: quotient from the registered product, then hash less C * quotient
  assign quo = HASH_W'(prod_r >> RED_SH);
  assign rem = hsh_r - HASH_W'(quo * HASH_W'(CAPACITY));

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_vld_r;
  assign out_rsp   = out_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    rvld_nxt      = rvld_r;
    ex_nxt        = ex_r;
    have_tomb_nxt = have_tomb_r;
    cnt_nxt       = cnt_r;
    out_vld_nxt   = out_vld_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    hsh_nxt       = hsh_r;
    prod_nxt      = prod_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    tomb_nxt      = tomb_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    we            = 1'b0;
    waddr         = q_r;
    wdata         = {SLOT_USED, key_r, val_r};

    // Drop the held result once the far side takes it
    if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        wdata = {SLOT_EMPTY, {(KEY_WIDTH + VALUE_WIDTH){1'b0}}};
        clr_nxt = clr_r + 1'b1;
        if (clr_r == IDX_LAST) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          op_nxt        = in_req.operation;
          key_nxt       = KEY_WIDTH'(in_req.key);
          val_nxt       = VALUE_WIDTH'(in_req.value);
          hsh_nxt       = in_req.hash;
          rvld_nxt      = 1'b0;
          ex_nxt        = '0;
          have_tomb_nxt = 1'b0;
          if (IS_POW2) begin
            p_nxt     = in_req.hash[IDX_W-1:0];
            state_nxt = S_PROBE;
          end else begin
            state_nxt = S_MOD;
          end
        end
      end

      S_MOD: begin
        // Multiply the hash by the reciprocal
        prod_nxt  = PROD_W'(hsh_r) * PROD_W'(RECIP_M);
        state_nxt = S_REM;
      end

      S_REM: begin
        p_nxt     = IDX_W'(rem);
        state_nxt = S_PROBE;
      end

      S_PROBE: begin
        // Issue the next read every cycle; judge the slot read last cycle
        p_nxt    = p_inc;
        q_nxt    = p_r;
        rvld_nxt = 1'b1;
        if (rvld_r) begin
          ex_nxt = ex_r + 1'b1;
          res_nxt.value_out = '0;
          res_nxt.slot      = '0;
          if (is_ins) begin
            if (hit) begin
              we    = 1'b1;
              waddr = q_r;
              res_nxt.status = STS_REPLACED;
              res_nxt.slot   = SLOT_W'(q_r);
              state_nxt = S_DONE;
            end else if (rd_st == SLOT_EMPTY ||
                         (last && (rd_st == SLOT_TOMB || have_tomb_r))) begin
              we      = 1'b1;
              waddr   = tgt;
              cnt_nxt = cnt_r + 1'b1;
              res_nxt.status = STS_INSERTED;
              res_nxt.slot   = SLOT_W'(tgt);
              state_nxt = S_DONE;
            end else if (last) begin
              res_nxt.status = STS_FULL;
              state_nxt = S_DONE;
            end else if (rd_st == SLOT_TOMB && !have_tomb_r) begin
              have_tomb_nxt = 1'b1;
              tomb_nxt      = q_r;
            end
          end else begin
            if (hit) begin
              res_nxt.value_out = VALUE_W'(rd_val);
              res_nxt.slot      = SLOT_W'(q_r);
              if (is_rem) begin
                we    = 1'b1;
                waddr = q_r;
                wdata = {SLOT_TOMB, rd_key, rd_val};
                if (cnt_r != '0) begin
                  cnt_nxt = cnt_r - 1'b1;
                end
                res_nxt.status = STS_REMOVED;
              end else begin
                res_nxt.status = STS_FOUND;
              end
              state_nxt = S_DONE;
            end else if (rd_st == SLOT_EMPTY || last) begin
              res_nxt.status = STS_NOT_FOUND;
              state_nxt = S_DONE;
            end
          end
          res_nxt.occupied = OCC_W'(cnt_nxt);
          if (state_nxt == S_DONE) begin
            rvld_nxt = 1'b0;
          end
        end
      end

      S_DONE: begin
        // Hold until the output register is free
        if (!out_vld_r || !out_stall) begin
          out_nxt     = res_r;
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      rvld_r      <= 1'b0;
      ex_r        <= '0;
      have_tomb_r <= 1'b0;
      cnt_r       <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rvld_r      <= rvld_nxt;
      ex_r        <= ex_nxt;
      have_tomb_r <= have_tomb_nxt;
      cnt_r       <= cnt_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    key_r  <= key_nxt;
    val_r  <= val_nxt;
    hsh_r  <= hsh_nxt;
    prod_r <= prod_nxt;
    p_r    <= p_nxt;
    q_r    <= q_nxt;
    tomb_r <= tomb_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

endmodule
`default_nettype wire
